// ----- rtl/prs_pkg.sv -----
package prs_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] key;
  } rec_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

// ----- rtl/prs_cell.sv -----
module prs_cell (
  input  logic              clk,
  input  prs_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  prs_pkg::rec_t     new_rec,
  input  prs_pkg::rec_t     prev_rec,
  input  logic              prev_take,
  input  prs_pkg::rec_t     next_rec,
  output prs_pkg::rec_t     rec,
  output logic              take
);

  // ties stay behind: only a strictly smaller key moves down
  assign take = !occupied || (rec.key < new_rec.key);

  always_ff @(posedge clk) begin
    if (ctl.insert && take) begin
      rec <= prev_take ? prev_rec : new_rec;
    end else if (ctl.shift) begin
      rec <= next_rec;
    end
  end

endmodule

// ----- rtl/priority_record_sorter_unit.sv -----
// descending record sorter
// input channel s_*: one record per transfer, s_tlast marks the end of a batch.
// each record is placed into a chain of compare-and-shift cells as it is
// accepted, so records load at one per cycle with ties kept in arrival order.
// records beyond MAX_RECORDS are dropped and the batch is flagged on m_tuser.
// after the record marked s_tlast, s_tready drops and the chain shifts toward
// the head into the output register, one record per cycle while the receiver
// keeps up; the first result follows the last input transfer through the state
// register and then the output register. m_tlast marks the final record of the batch.
// when the receiver holds m_tready low the output register and the chain
// hold; draining resumes as soon as the register frees up.
// s_tready rises again at the same edge at which the final record enters the
// output register, so a new batch loads while that record still waits.
// reset (rst, synchronous) empties the chain and the output register.
module priority_record_sorter_unit #(
  parameter int MAX_RECORDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // priority_key, job_tag
  input  logic        s_tlast,  // batch_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // sorted_key, sorted_tag
  output logic        m_tlast,  // final_record
  output logic        m_tuser   // overflowed
);

  localparam int FILL_W = $clog2(MAX_RECORDS + 1);
  localparam logic [FILL_W-1:0] FULL = FILL_W'(MAX_RECORDS);
  localparam logic [FILL_W-1:0] ONE  = FILL_W'(1);

  prs_pkg::state_t    state, state_next;
  logic [FILL_W-1:0]  fill, fill_next;
  logic               drop, drop_next;
  prs_pkg::cell_ctl_t ctl;
  prs_pkg::rec_t      new_rec;
  prs_pkg::rec_t      recs [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] takes;
  logic [MAX_RECORDS-1:0] occ;
  logic in_xfer, full, out_free, last_out;

  assign new_rec  = s_tdata;
  assign in_xfer  = s_tvalid && s_tready;
  assign full     = (fill == FULL);
  assign out_free = !m_tvalid || m_tready;
  assign last_out = ctl.shift && (fill == ONE);

  always_comb begin
    state_next = state;
    case (state)
      prs_pkg::ST_LOAD: begin
        if (in_xfer && s_tlast) state_next = prs_pkg::ST_DRAIN;
      end
      prs_pkg::ST_DRAIN: begin
        if (last_out) state_next = prs_pkg::ST_LOAD;
      end
      default: state_next = prs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    ctl.insert = 1'b0;
    ctl.shift  = 1'b0;
    case (state)
      prs_pkg::ST_LOAD: begin
        s_tready   = 1'b1;
        ctl.insert = s_tvalid && !full;
      end
      prs_pkg::ST_DRAIN: begin
        ctl.shift = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    fill_next = fill;
    drop_next = drop;
    if (ctl.insert) fill_next = fill + ONE;
    if (ctl.shift) fill_next = fill - ONE;
    if (in_xfer && full) drop_next = 1'b1;
    if (last_out) drop_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prs_pkg::ST_LOAD;
      fill  <= '0;
      drop  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      drop  <= drop_next;
    end
  end

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    assign occ[i] = (FILL_W'(i) < fill);
    prs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occ[i]),
      .new_rec   (new_rec),
      .prev_rec  ((i == 0) ? new_rec : recs[(i == 0) ? 0 : i - 1]),
      .prev_take ((i == 0) ? 1'b0 : takes[(i == 0) ? 0 : i - 1]),
      .next_rec  (recs[(i == MAX_RECORDS - 1) ? i : i + 1]),
      .rec       (recs[i]),
      .take      (takes[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.shift) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      m_tdata <= recs[0];
      m_tlast <= (fill == ONE);
      m_tuser <= drop;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill count above capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == prs_pkg::ST_DRAIN |-> fill != '0)
    else $error("draining an empty chain");

  a_batch_done: assert property (@(posedge clk) disable iff (rst)
    last_out |=> state == prs_pkg::ST_LOAD && fill == '0 && !drop && m_tvalid && m_tlast)
    else $error("batch did not close cleanly");

  a_batch_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer && s_tlast |=> state == prs_pkg::ST_DRAIN && !s_tready)
    else $error("batch end did not start draining");

endmodule

// ----- dv/priority_record_sorter_unit_test.sv -----
module priority_record_sorter_unit_test;

  localparam int DEPTH = 32;
  localparam int RANDOM_ITEMS_PER_PHASE = 135;

  typedef struct {
    logic [31:0] key;
    logic [15:0] tag;
    logic        fin;
    logic        ovf;
  } sorted_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // priority_key, job_tag
  logic        s_tlast = 1'b0;  // batch_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;  // sorted_key, sorted_tag
  logic        m_tlast;  // final_record
  logic        m_tuser;  // overflowed

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int error_count = 0;
  int items_sent = 0;

  // sorted batch image kept in descending order, ties in arrival order
  logic [31:0] held_keys [DEPTH];
  logic [15:0] held_tags [DEPTH];
  int          held_count = 0;
  logic        held_dropped = 1'b0;
  sorted_rec_t pending_sorted[$];

  priority_record_sorter_unit #(
    .MAX_RECORDS(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic admit_record(input logic [31:0] key, input logic [15:0] tag,
                              input logic last);
    int pos;
    sorted_rec_t rec;
    if (held_count < DEPTH) begin
      pos = 0;
      while (pos < held_count && held_keys[pos] >= key) pos++;
      for (int k = held_count; k > pos; k--) begin
        held_keys[k] = held_keys[k-1];
        held_tags[k] = held_tags[k-1];
      end
      held_keys[pos] = key;
      held_tags[pos] = tag;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (last) begin
      for (int k = 0; k < held_count; k++) begin
        rec.key = held_keys[k];
        rec.tag = held_tags[k];
        rec.fin = (k == held_count - 1);
        rec.ovf = held_dropped;
        pending_sorted.push_back(rec);
      end
      held_count = 0;
      held_dropped = 1'b0;
    end
  endtask

  // called right after an accepting edge or after a negedge-aligned wait
  task automatic send_record(input logic [31:0] key, input logic [15:0] tag,
                             input logic last);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {tag, key};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    admit_record(key, tag, last);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_sorted.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    sorted_rec_t exp_rec;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_sorted.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer key=%0h tag=%0h",
                                  m_tdata[31:0], m_tdata[47:32]));
      end else begin
        exp_rec = pending_sorted.pop_front();
        if (m_tdata[31:0] !== exp_rec.key)
          report_mismatch($sformatf("sorted_key got %0h exp %0h",
                                    m_tdata[31:0], exp_rec.key));
        if (m_tdata[47:32] !== exp_rec.tag)
          report_mismatch($sformatf("sorted_tag got %0h exp %0h",
                                    m_tdata[47:32], exp_rec.tag));
        if (m_tlast !== exp_rec.fin)
          report_mismatch($sformatf("final_record got %0b exp %0b", m_tlast, exp_rec.fin));
        if (m_tuser !== exp_rec.ovf)
          report_mismatch($sformatf("overflowed got %0b exp %0b", m_tuser, exp_rec.ovf));
      end
    end
  end

  function automatic logic [31:0] pick_key();
    case ($urandom_range(4))
      0: return $urandom_range(3);
      1: return 32'($urandom_range(3)) << 16;
      2: return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_single_record();
    send_record(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_record(32'h0000_0000, 16'h0000, 1'b1);
  endtask

  task automatic test_extremes();
    send_record(32'h0000_0000, 16'hFFFF, 1'b0);
    send_record(32'hFFFF_FFFF, 16'h0000, 1'b0);
    send_record(32'h8000_0000, 16'h8000, 1'b0);
    send_record(32'h0001_0000, 16'h0001, 1'b0);
    send_record(32'h7FFF_FFFF, 16'h7FFF, 1'b0);
    send_record(32'h0000_0001, 16'hAAAA, 1'b1);
  endtask

  task automatic test_ties();
    send_record(32'h0000_0005, 16'h0001, 1'b0);
    send_record(32'h0000_0005, 16'h0002, 1'b0);
    send_record(32'h0000_0009, 16'h0003, 1'b0);
    send_record(32'h0000_0005, 16'h0004, 1'b0);
    send_record(32'h0000_0009, 16'h0005, 1'b1);
    for (int i = 0; i < 4; i++) send_record(32'h1234_5678, 16'(16'h5555 + i), (i == 3));
  endtask

  task automatic run_random_batches(input int budget);
    int start_count;
    int batch_len;
    start_count = items_sent;
    while (items_sent - start_count < budget) begin
      case ($urandom_range(11))
        0: batch_len = DEPTH;
        1: batch_len = DEPTH + 1;
        2: batch_len = DEPTH + 2 + $urandom_range(6);
        default: batch_len = 1 + $urandom_range(9);
      endcase
      for (int i = 0; i < batch_len; i++)
        send_record(pick_key(), 16'($urandom_range(65535)), (i == batch_len - 1));
      if ($urandom_range(7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_random_stalls();
    src_idle_pct = 35;
    sink_idle_pct = 77;
    run_random_batches(RANDOM_ITEMS_PER_PHASE);
    src_idle_pct = 77;
    sink_idle_pct = 35;
    run_random_batches(RANDOM_ITEMS_PER_PHASE);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    run_random_batches(RANDOM_ITEMS_PER_PHASE);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_single_record();
    test_extremes();
    test_ties();
    wait_drained();
    test_random_stalls();
    wait_drained();
    repeat (DEPTH + 8) @(posedge clk);
    while (pending_sorted.size() != 0) begin
      report_mismatch($sformatf("missing result key=%0h", pending_sorted[0].key));
      void'(pending_sorted.pop_front());
    end
    if (error_count == 0) begin
      $display("priority_record_sorter_unit_test: done, clean");
    end else begin
      $display("priority_record_sorter_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("priority_record_sorter_unit_test: done, errors");
    $finish;
  end

endmodule
